[hw/rtl/bcc_pkg.sv]
// Shared types and constants for the barycentric coordinates pipeline.
// Used by bcc_divider and barycentric_coordinates; depends on nothing.
`default_nettype none

package bcc_pkg;

    localparam int COORD_W  = 16;
    localparam int NCOORD   = 12;
    localparam int DIFF_W   = 17;
    localparam int PROD_W   = 34;
    localparam int DOT_W    = 36;
    localparam int NUM_W    = 72;
    localparam int DEN_W    = 68;
    localparam int QBITS    = 41;
    localparam int Q_SHIFT  = 16;
    localparam int HI_W     = NUM_W - QBITS + Q_SHIFT;
    localparam int WV_W     = QBITS + 2;
    localparam int WEIGHT_W = 32;
    localparam int DIV_LAT  = QBITS + 2;

    localparam logic [QBITS-1:0] QUOT_LIMIT = QBITS'(1) << (QBITS - 1);

    localparam logic [31:0] AREA_THR_RESET = 32'd4295;
    localparam logic [15:0] LEN_THR_RESET  = 16'd1;

    localparam logic [0:0] CFG_AREA_THR = 1'b0;
    localparam logic [0:0] CFG_LEN_THR  = 1'b1;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QBITS-1:0] low;
        logic [QBITS-1:0] q;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             ovf;
    } bcc_div_t;

    typedef struct packed {
        logic deg;
        logic use_b;
        logic short_edge;
    } bcc_side_t;

endpackage

`default_nettype wire

[hw/rtl/bcc_divider.sv]
// Pipelined restoring divider: trunc(num * 2^16 / den), magnitude held at 2^40.
// One quotient bit per stage; depends on bcc_pkg.
`default_nettype none

module bcc_divider
    import bcc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic        [DEN_W-1:0] den,
    output logic             [QBITS-1:0] mag,
    output logic                         neg
);

    logic [NUM_W-1:0] abs_reg;
    logic [DEN_W-1:0] den0_reg;
    logic             neg0_reg;
    bcc_div_t         st_reg [0:QBITS];
    bcc_div_t         init_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abs_reg  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            den0_reg <= den;
            neg0_reg <= num[NUM_W-1];
        end
    end

    always_comb
    begin
        init_next.rem = {{(DEN_W-HI_W){1'b0}}, abs_reg[NUM_W-1:QBITS-Q_SHIFT]};
        init_next.low = {abs_reg[QBITS-Q_SHIFT-1:0], {Q_SHIFT{1'b0}}};
        init_next.q   = '0;
        init_next.den = den0_reg;
        init_next.neg = neg0_reg;
        init_next.ovf = init_next.rem >= den0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= init_next;
        end
    end

    for (genvar g = 1; g <= QBITS; g++)
    begin : g_step
        logic [DEN_W:0] trial;
        bcc_div_t       step_next;

        always_comb
        begin
            step_next = st_reg[g-1];
            trial     = {st_reg[g-1].rem, st_reg[g-1].low[QBITS-1]};
            step_next.low = {st_reg[g-1].low[QBITS-2:0], 1'b0};
            if (trial >= {1'b0, st_reg[g-1].den})
            begin
                step_next.rem = DEN_W'(trial - {1'b0, st_reg[g-1].den});
                step_next.q   = {st_reg[g-1].q[QBITS-2:0], 1'b1};
            end
            else
            begin
                step_next.rem = trial[DEN_W-1:0];
                step_next.q   = {st_reg[g-1].q[QBITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g] <= step_next;
            end
        end
    end

    assign mag = (st_reg[QBITS].ovf || st_reg[QBITS].q > QUOT_LIMIT)
                 ? QUOT_LIMIT : st_reg[QBITS].q;
    assign neg = st_reg[QBITS].neg;

endmodule

`default_nettype wire

[hw/rtl/barycentric_coordinates.sv]
// Barycentric weights of a point against a 3D triangle, fully pipelined.
// Depends on bcc_pkg and bcc_divider.
//
// Usage: the input stream carries three vertices and a query point, each
// coordinate signed Q8.8. The output stream carries the three weights in
// signed Q16.16, saturated, with flags for the degenerate edge fallback and
// for clamping. Exactly one output transfer follows each input transfer, in
// order.
// Throughput is one item per cycle while the skid register is empty. On its way
// to m_axis_tvalid an item passes six arithmetic stages, 43 divider stages (one
// quotient bit per stage plus two setup stages), two result stages and the
// output register. The three weight divisions run in parallel dividers.
// When the receiver stalls, one extra item is caught in a skid register and
// the whole pipeline then holds, with s_axis_tready low, until the output
// drains. Reset empties the pipeline and loads area_threshold with 4295 and
// length_threshold with 1. Thresholds are written through cfg_wr_en,
// cfg_index and cfg_data and should be changed only while the block is empty.
`default_nettype none

module barycentric_coordinates
    import bcc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, pt_x, pt_y, pt_z
    input  wire logic [191:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // weight_a, weight_b, weight_c
    output logic [95:0]       m_axis_tdata,
    // degenerate, saturated
    output logic [1:0]        m_axis_tuser,
    input  wire logic         cfg_wr_en,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    localparam int NSTAGE = 6 + DIV_LAT + 2;
    localparam int D00 = 0;
    localparam int D01 = 1;
    localparam int D11 = 2;
    localparam int D20 = 3;
    localparam int D21 = 4;

    logic [31:0] area_thr_reg;
    logic [15:0] len_thr_reg;
    logic        adv;
    logic [NSTAGE-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_thr_reg <= AREA_THR_RESET;
            len_thr_reg  <= LEN_THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_AREA_THR: area_thr_reg <= cfg_data;
                CFG_LEN_THR:  len_thr_reg  <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // Stage 1: edge and offset vectors.
    logic signed [DIFF_W-1:0] e_reg  [0:2][0:2];
    logic signed [DIFF_W-1:0] e_next [0:2][0:2];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int v = 0; v < 3; v++)
            begin
                e_next[v][k] =
                    DIFF_W'($signed(s_axis_tdata[COORD_W*(3*(v+1)+k) +: COORD_W]))
                    - DIFF_W'($signed(s_axis_tdata[COORD_W*k +: COORD_W]));
            end
        end
    end

    // Stage 2: per-axis products. Stage 3: dot products.
    logic signed [PROD_W-1:0] p_reg [0:4][0:2];
    logic signed [DOT_W-1:0]  d_reg [0:4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg <= e_next;
            for (int k = 0; k < 3; k++)
            begin
                p_reg[D00][k] <= e_reg[0][k] * e_reg[0][k];
                p_reg[D01][k] <= e_reg[0][k] * e_reg[1][k];
                p_reg[D11][k] <= e_reg[1][k] * e_reg[1][k];
                p_reg[D20][k] <= e_reg[2][k] * e_reg[0][k];
                p_reg[D21][k] <= e_reg[2][k] * e_reg[1][k];
            end
            for (int j = 0; j < 5; j++)
            begin
                d_reg[j] <= DOT_W'(p_reg[j][0]) + DOT_W'(p_reg[j][1])
                            + DOT_W'(p_reg[j][2]);
            end
        end
    end

    // Stage 4: cross products. Stage 5: determinant and numerators.
    logic signed [NUM_W-1:0] m_reg [0:5];
    logic signed [DOT_W-1:0] d4_reg [0:4];
    logic signed [DOT_W-1:0] d5_reg [0:4];
    logic signed [NUM_W-1:0] det_reg, nb_reg, nc_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg[0] <= d_reg[D00] * d_reg[D11];
            m_reg[1] <= d_reg[D01] * d_reg[D01];
            m_reg[2] <= d_reg[D11] * d_reg[D20];
            m_reg[3] <= d_reg[D01] * d_reg[D21];
            m_reg[4] <= d_reg[D00] * d_reg[D21];
            m_reg[5] <= d_reg[D01] * d_reg[D20];
            d4_reg   <= d_reg;
            det_reg  <= m_reg[0] - m_reg[1];
            nb_reg   <= m_reg[2] - m_reg[3];
            nc_reg   <= m_reg[4] - m_reg[5];
            d5_reg   <= d4_reg;
        end
    end

    // Stage 6: degenerate test and divider operands.
    logic signed [NUM_W-1:0] na_next;
    logic signed [DOT_W-1:0] len, dot;
    bcc_side_t               side_next;
    logic signed [NUM_W-1:0] num_a_reg, num_b_reg, num_c_reg;
    logic        [DEN_W-1:0] den_reg, den_b_reg;
    logic signed [NUM_W-1:0] num_b_next;
    logic        [DEN_W-1:0] den_b_next;
    bcc_side_t               side_reg;

    always_comb
    begin
        na_next = det_reg - nb_reg - nc_reg;
        side_next.deg = det_reg[NUM_W-1] || (det_reg == '0)
                        || ((det_reg[NUM_W-1:32] == '0)
                            && (det_reg[31:0] < area_thr_reg));
        side_next.use_b = d5_reg[D00] > d5_reg[D11];
        len = side_next.use_b ? d5_reg[D00] : d5_reg[D11];
        dot = side_next.use_b ? d5_reg[D20] : d5_reg[D21];
        side_next.short_edge = len[DOT_W-1] || (len == '0)
                               || ($unsigned(len) < DOT_W'(len_thr_reg));
        num_b_next = side_next.deg ? NUM_W'(dot) : nb_reg;
        den_b_next = side_next.deg ? DEN_W'(len[PROD_W-1:0]) : det_reg[DEN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_a_reg <= na_next;
            num_b_reg <= num_b_next;
            num_c_reg <= nc_reg;
            den_reg   <= det_reg[DEN_W-1:0];
            den_b_reg <= den_b_next;
            side_reg  <= side_next;
        end
    end

    logic [QBITS-1:0] mag_a, mag_b, mag_c;
    logic             neg_a, neg_b, neg_c;

    bcc_divider u_div_a (
        .clk (clk), .en (adv), .num (num_a_reg), .den (den_reg),
        .mag (mag_a), .neg (neg_a)
    );

    bcc_divider u_div_b (
        .clk (clk), .en (adv), .num (num_b_reg), .den (den_b_reg),
        .mag (mag_b), .neg (neg_b)
    );

    bcc_divider u_div_c (
        .clk (clk), .en (adv), .num (num_c_reg), .den (den_reg),
        .mag (mag_c), .neg (neg_c)
    );

    bcc_side_t side_pipe_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_pipe_reg[0] <= side_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_pipe_reg[i] <= side_pipe_reg[i-1];
            end
        end
    end

    // Result stages: select weights, then saturate.
    function automatic logic signed [WV_W-1:0] signed_mag(
        input logic [QBITS-1:0] m, input logic n);
        logic signed [WV_W-1:0] s;
        s = $signed({2'b00, m});
        return n ? -s : s;
    endfunction

    function automatic logic [WEIGHT_W-1:0] sat32(input logic signed [WV_W-1:0] v);
        if (v > WV_W'(33'sh0_7FFF_FFFF))
            return 32'h7FFF_FFFF;
        else if (v < -WV_W'(33'sh0_8000_0000))
            return 32'h8000_0000;
        else
            return v[WEIGHT_W-1:0];
    endfunction

    function automatic logic clamps(input logic signed [WV_W-1:0] v);
        return (v > WV_W'(33'sh0_7FFF_FFFF)) || (v < -WV_W'(33'sh0_8000_0000));
    endfunction

    logic signed [WV_W-1:0] sv_a, sv_b, sv_c, t;
    logic signed [WV_W-1:0] wa_next, wb_next, wc_next;
    logic signed [WV_W-1:0] wa_reg, wb_reg, wc_reg;
    logic                   deg_f1_reg;
    logic [WEIGHT_W-1:0]    fa_reg, fb_reg, fc_reg;
    logic                   deg_f2_reg, sat_f2_reg;
    bcc_side_t              side_out;

    always_comb
    begin
        side_out = side_pipe_reg[DIV_LAT-1];
        sv_a = signed_mag(mag_a, neg_a);
        sv_b = signed_mag(mag_b, neg_b);
        sv_c = signed_mag(mag_c, neg_c);
        t    = side_out.short_edge ? WV_W'(32768) : sv_b;
        if (side_out.deg)
        begin
            wa_next = WV_W'(65536) - t;
            wb_next = side_out.use_b ? t : '0;
            wc_next = side_out.use_b ? '0 : t;
        end
        else
        begin
            wa_next = sv_a;
            wb_next = sv_b;
            wc_next = sv_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wa_reg     <= wa_next;
            wb_reg     <= wb_next;
            wc_reg     <= wc_next;
            deg_f1_reg <= side_out.deg;
            fa_reg     <= sat32(wa_reg);
            fb_reg     <= sat32(wb_reg);
            fc_reg     <= sat32(wc_reg);
            deg_f2_reg <= deg_f1_reg;
            sat_f2_reg <= clamps(wa_reg) || clamps(wb_reg) || clamps(wc_reg);
        end
    end

    // Valid bits and output register with skid.
    logic        arrive;
    logic        out_valid_reg, skid_valid_reg;
    logic [95:0] out_data_reg, skid_data_reg;
    logic [1:0]  out_user_reg, skid_user_reg;

    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;
    assign arrive        = adv && v_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NSTAGE-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !m_axis_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !m_axis_tready)
            begin
                skid_data_reg <= {fc_reg, fb_reg, fa_reg};
                skid_user_reg <= {sat_f2_reg, deg_f2_reg};
            end
            else
            begin
                out_data_reg <= {fc_reg, fb_reg, fa_reg};
                out_user_reg <= {sat_f2_reg, deg_f2_reg};
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while the output is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid register filled while the output was not stalled");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline valid bits moved during a stall");

    a_degen_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0])
            |-> (m_axis_tdata[63:32] == '0 || m_axis_tdata[95:64] == '0))
        else $error("degenerate result without a zero weight");

endmodule

`default_nettype wire

[verif/bcc_checker.sv]
// Checker for barycentric_coordinates: predicts the weights of each input transfer
// and compares every output transfer in order. Depends on bcc_pkg.
`default_nettype none

module bcc_checker
    import bcc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [191:0] s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [95:0]  m_axis_tdata,
    input  wire logic [1:0]   m_axis_tuser,
    input  wire logic         cfg_wr_en,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic       saturated;
        logic       degenerate;
        logic [31:0] weight_c;
        logic [31:0] weight_b;
        logic [31:0] weight_a;
    } weights_t;

    weights_t    weights_due[$];
    logic [31:0] area_thr;
    logic [15:0] len_thr;

    assign pending = weights_due.size();

    function automatic logic signed [63:0] quot_q16(logic signed [127:0] num,
                                                    logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        logic [63:0]  m;
        mag = num[127] ? 128'(-num) : 128'(num);
        q = (mag << 16) / 128'(den);
        m = (q > 128'(64'd1 << 40)) ? (64'd1 << 40) : q[63:0];
        return num[127] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] clamp32(logic signed [63:0] v, inout logic hit);
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic weights_t predict_weights(logic [191:0] d);
        logic signed [63:0]  e0 [3];
        logic signed [63:0]  e1 [3];
        logic signed [63:0]  e2 [3];
        logic signed [63:0]  a, d00, d01, d11, d20, d21, len, dot, t, wa, wb, wc;
        logic signed [127:0] det, nb, nc, na;
        logic [63:0]         m;
        logic                deg, use_b, hit;
        weights_t            r;
        d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
        for (int k = 0; k < 3; k++)
        begin
            a = $signed(d[16*k +: 16]);
            e0[k] = $signed(d[16*(3+k) +: 16]) - a;
            e1[k] = $signed(d[16*(6+k) +: 16]) - a;
            e2[k] = $signed(d[16*(9+k) +: 16]) - a;
            d00 += e0[k] * e0[k];
            d01 += e0[k] * e1[k];
            d11 += e1[k] * e1[k];
            d20 += e2[k] * e0[k];
            d21 += e2[k] * e1[k];
        end
        det = 128'(d00) * 128'(d11) - 128'(d01) * 128'(d01);
        deg = (det <= 0) || (det < $signed({96'd0, area_thr}));
        if (deg)
        begin
            use_b = d00 > d11;
            len = use_b ? d00 : d11;
            dot = use_b ? d20 : d21;
            if (len <= 0 || len < $signed({48'd0, len_thr}))
                t = 32768;
            else
            begin
                m = ((dot < 0 ? 64'(-dot) : 64'(dot)) << 16) / 64'(len);
                t = dot < 0 ? -$signed(m) : $signed(m);
            end
            wa = 65536 - t;
            wb = use_b ? t : 0;
            wc = use_b ? 0 : t;
        end
        else
        begin
            nb = 128'(d11) * 128'(d20) - 128'(d01) * 128'(d21);
            nc = 128'(d00) * 128'(d21) - 128'(d01) * 128'(d20);
            na = det - nb - nc;
            wa = quot_q16(na, det);
            wb = quot_q16(nb, det);
            wc = quot_q16(nc, det);
        end
        hit = 1'b0;
        r.weight_a = clamp32(wa, hit);
        r.weight_b = clamp32(wb, hit);
        r.weight_c = clamp32(wc, hit);
        r.degenerate = deg;
        r.saturated = hit;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        weights_t w;
        if (!rst_n)
        begin
            area_thr <= AREA_THR_RESET;
            len_thr <= LEN_THR_RESET;
            fail_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_AREA_THR)
                    area_thr <= cfg_data;
                else
                    len_thr <= cfg_data[15:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                weights_due.push_back(predict_weights(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (weights_due.size() == 0)
                    report_mismatch("unexpected transfer", 0, 0);
                else
                begin
                    w = weights_due.pop_front();
                    if (m_axis_tdata[31:0] !== w.weight_a)
                        report_mismatch("weight_a", m_axis_tdata[31:0], w.weight_a);
                    if (m_axis_tdata[63:32] !== w.weight_b)
                        report_mismatch("weight_b", m_axis_tdata[63:32], w.weight_b);
                    if (m_axis_tdata[95:64] !== w.weight_c)
                        report_mismatch("weight_c", m_axis_tdata[95:64], w.weight_c);
                    if (m_axis_tuser[0] !== w.degenerate)
                        report_mismatch("degenerate", 32'(m_axis_tuser[0]),
                                        32'(w.degenerate));
                    if (m_axis_tuser[1] !== w.saturated)
                        report_mismatch("saturated", 32'(m_axis_tuser[1]),
                                        32'(w.saturated));
                end
            end
        end
    end

endmodule

`default_nettype wire

[verif/tb.sv]
// Top of the barycentric_coordinates testbench: clock, reset, stimulus and verdict.
// Depends on bcc_pkg, bcc_checker and the block itself.
`default_nettype none

module tb
    import bcc_pkg::*;
;

    localparam int LATENCY = 52;
    localparam int IDLE_LIMIT = 4000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_wr_en = 1'b0;
    logic [0:0]   cfg_index = CFG_AREA_THR;
    logic [31:0]  cfg_data = '0;
    int           fail_count;
    int           pending;
    logic         sink_gaps = 1'b1;
    logic         hold_sink = 1'b0;
    int           idle_cycles = 0;
    int           sink_idle = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    barycentric_coordinates dut (.*);
    bcc_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver stalls in random bursts, or is held off.
    always @(posedge clk)
    begin
        if (hold_sink)
            m_axis_tready <= 1'b0;
        else if (sink_idle > 0)
        begin
            sink_idle <= sink_idle - 1;
            m_axis_tready <= 1'b0;
        end
        else if (m_axis_tready && sink_gaps && $urandom_range(0, 5) == 0)
        begin
            sink_idle <= int'($urandom_range(0, 2));
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic logic [15:0] pick_coord(int mode);
        case (mode)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [191:0] d, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_items(int count, bit gaps);
        logic [191:0] d;
        int           mode;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 9);
            for (int f = 0; f < 12; f++)
                d[16*f +: 16] = pick_coord(mode < 2 ? $urandom_range(0, 3) :
                                           (mode < 6 ? 2 : 3));
            // Near-degenerate triangles: c on or near the line through a and b.
            if (mode == 6 || mode == 7)
                for (int f = 0; f < 3; f++)
                    d[16*(6+f) +: 16] = 16'(d[16*f +: 16] + (d[16*(3+f) +: 16] -
                                        d[16*f +: 16]) * (mode - 5) +
                                        16'($urandom_range(0, 1)));
            if (mode == 8)
                d[95:48] = d[47:0];
            send_item(d, gaps);
        end
    endtask

    initial
    begin
        logic [191:0] d;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, coincident vertices, collinear, tiny and huge triangles.
        send_item({16{12'd0}}, 0);
        send_item({12{16'h7fff}}, 0);
        send_item({12{16'h8000}}, 0);
        send_item({48'h0, 48'h0000_0000_0100, 48'h0000_0100_0000,
                   48'h0000_0000_0000}, 0);
        send_item({48'h0040_0040_0000, 48'h0000_0000_0100, 48'h0000_0100_0000,
                   48'h0}, 0);
        send_item({48'h0, 48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'h0}, 0);
        send_item({48'h7fff_7fff_7fff, 48'h0000_0001_0000, 48'h0000_0000_0001,
                   48'h0}, 0);
        send_item({48'h8000_0000_7fff, 48'h0000_0000_0200, 48'h0000_0000_0100,
                   48'h0}, 0);
        send_item({48'h1234_8000_7fff, 48'h0001_0000_0000, 48'h0000_0000_0001,
                   48'h0}, 0);
        send_item({48'h0, 48'h0, 48'h0000_0000_0300, 48'h0}, 0);
        send_item({48'h0, 48'h0000_0000_0001, 48'h0, 48'h0}, 0);
        send_item({48'h7fff_0000_0000, 48'h0, 48'h0, 48'h8000_0000_0000}, 0);
        for (int i = 0; i < 8; i++)
        begin
            for (int f = 0; f < 12; f++)
                d[16*f +: 16] = pick_coord($urandom_range(0, 1));
            send_item(d, 0);
        end
        random_items(100, 1);
        drain();

        write_reg(CFG_AREA_THR, 32'd0);
        write_reg(CFG_LEN_THR, 32'd0);
        random_items(150, 1);
        drain();

        write_reg(CFG_AREA_THR, 32'hffffffff);
        write_reg(CFG_LEN_THR, 32'h0000ffff);
        random_items(150, 1);

        // Long hold-off on the receiver while the sender keeps offering.
        hold_sink <= 1'b1;
        fork
            random_items(120, 0);
            begin
                repeat (300) @(posedge clk);
                hold_sink <= 1'b0;
            end
        join
        drain();

        write_reg(CFG_AREA_THR, $urandom);
        write_reg(CFG_LEN_THR, $urandom_range(0, 65535));
        random_items(200, 1);
        drain();

        write_reg(CFG_AREA_THR, 32'd4295);
        write_reg(CFG_LEN_THR, 32'd1);
        sink_gaps <= 1'b0;
        random_items(200, 0);
        drain();

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
